FILE: hdl/osrv_pkg.sv
// Shared constants, codes and types of the oldest-or-highest-value server.
`default_nettype none

package osrv_pkg;

   localparam int unsigned CAPACITY    = 1024;
   localparam int unsigned VALUE_BITS  = 32;
   localparam int unsigned AMOUNT_BITS = 32;
   localparam int unsigned MODE_BITS   = 2;
   localparam int unsigned STATUS_BITS = 2;
   localparam int unsigned ID_BITS     = $clog2(CAPACITY + 1);
   localparam int unsigned ADDR_BITS   = $clog2(CAPACITY);
   // One stored entry: served mark on top, value below it.
   localparam int unsigned ENTRY_BITS  = VALUE_BITS + 1;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ARRIVE  = 2'd0,
      MODE_OLDEST  = 2'd1,
      MODE_HIGHEST = 2'd2
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_STORED = 2'd0,
      STATUS_SERVED = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_POST
   } state_type;

   typedef struct packed {
      logic                 clear;
      logic                 eval;
      logic [ID_BITS-1:0]   id;
   } scan_ctl_type;

   typedef struct packed {
      logic                  take;
      logic                  found;
      logic [ID_BITS-1:0]    best_id;
      logic [VALUE_BITS-1:0] best_val;
   } scan_sts_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic [ENTRY_BITS-1:0] wr_data;
      logic [ADDR_BITS-1:0]  rd_addr;
   } ram_ctl_type;

endpackage

`default_nettype wire

FILE: hdl/osrv_req_if.sv
// Request channel: mode and amount of one item with a valid/ready handshake.
`default_nettype none

interface osrv_req_if;
   logic                               valid;
   logic                               ready;
   logic [osrv_pkg::MODE_BITS-1:0]     mode;
   logic [osrv_pkg::AMOUNT_BITS-1:0]   amount;

   modport source (output valid, output mode, output amount, input ready);
   modport sink   (input valid, input mode, input amount, output ready);
endinterface

`default_nettype wire

FILE: hdl/osrv_rsp_if.sv
// Response channel: status and entry id of one item with a valid/ready handshake.
`default_nettype none

interface osrv_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [osrv_pkg::STATUS_BITS-1:0]   status;
   logic [osrv_pkg::ID_BITS-1:0]       entry_id;

   modport source (output valid, output status, output entry_id, input ready);
   modport sink   (input valid, input status, input entry_id, output ready);
endinterface

`default_nettype wire

FILE: hdl/oldest_or_highest_value_server_unit.sv
// Top level of the oldest-or-highest-value server: sequencer, compare unit and entry store.
//
// Items enter on req_port (mode, amount) and leave on rsp_port (status, entry_id),
// both valid/ready channels; every request item gives exactly one response item.
// An arrival stores its amount under the next id, counting from 1. A serve item
// marks and returns either the oldest unserved id or the unserved id with the
// largest value, the lower id winning a tie. A full store or an empty waiting
// list is reported through the status code with entry_id zero.
// The block takes one item at a time: req_port.ready is high only while idle.
// An arrival, a refused serve or an unused mode passes from idle through the
// post state, which loads the response register, and back to idle. A serve walks the
// entry store one id per cycle through its single read port: serve-oldest reads
// from the oldest pointer up to the first unserved id, serve-highest reads every
// id handed out; the post state then loads the response and marks the winner.
// The response sits in an output register; while the receiver stalls the block
// finishes its current item and then holds it until the response is taken.
// Synchronous reset clears the id counter, the oldest pointer and the control
// state; the store needs no clearing pass, since only ids up to the counter
// are read and each arrival writes its served mark clear. Ready follows reset.
`default_nettype none

module oldest_or_highest_value_server_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   osrv_req_if.sink    req_port,
   osrv_rsp_if.source  rsp_port
);

   osrv_pkg::ram_ctl_type               ram_ctl;
   osrv_pkg::scan_ctl_type              scan_ctl;
   osrv_pkg::scan_sts_type              scan_sts;
   logic [osrv_pkg::ENTRY_BITS-1:0]     rd_data;

   // Sequencer owns the handshakes, the id counter and the oldest pointer.
   osrv_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port),
      .ram_ctl  (ram_ctl),
      .scan_ctl (scan_ctl),
      .scan_sts (scan_sts)
   );

   // One compare unit serves both kinds of serve: the first unserved entry
   // always wins, and later ones win only with a strictly larger value.
   osrv_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .rd_data (rd_data),
      .sts     (scan_sts)
   );

   // Entry store: served mark and value per id, at address id - 1.
   osrv_ram #(
      .WIDTH (osrv_pkg::ENTRY_BITS),
      .DEPTH (osrv_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (ram_ctl.wr_data),
      .rd_addr (ram_ctl.rd_addr),
      .rd_data (rd_data)
   );

`ifndef ASSERT_OFF
   // After an item is taken the block is busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready |=> !req_port.ready)
      else $error("request accepted on two consecutive cycles");

   // Refusals always carry id zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && (rsp_port.status == osrv_pkg::STATUS_FULL ||
                         rsp_port.status == osrv_pkg::STATUS_EMPTY)
      |-> rsp_port.entry_id == '0)
      else $error("refusal response with nonzero id");

   // Stored and served items always name a real id.
   assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && (rsp_port.status == osrv_pkg::STATUS_SERVED ||
                         rsp_port.status == osrv_pkg::STATUS_STORED)
      |-> rsp_port.entry_id != '0)
      else $error("stored or served response with id zero");
`endif

endmodule

`default_nettype wire

FILE: hdl/osrv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module osrv_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hdl/osrv_scan.sv
// Shared compare unit that tracks the best unserved entry during a scan.
`default_nettype none

module osrv_scan (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire osrv_pkg::scan_ctl_type             ctl,
   input  wire logic [osrv_pkg::ENTRY_BITS-1:0]    rd_data,
   output      osrv_pkg::scan_sts_type             sts
);

   logic                              found_ff, found_in;
   logic [osrv_pkg::ID_BITS-1:0]      best_id_ff, best_id_in;
   logic [osrv_pkg::VALUE_BITS-1:0]   best_val_ff, best_val_in;
   logic                              mark;
   logic [osrv_pkg::VALUE_BITS-1:0]   value;
   logic                              take;

   assign mark  = rd_data[osrv_pkg::VALUE_BITS];
   assign value = rd_data[osrv_pkg::VALUE_BITS-1:0];

   // A strictly larger value wins, so ties stay with the earlier id.
   assign take = ctl.eval && !mark && (!found_ff || (value > best_val_ff));

   always_comb begin
      found_in    = found_ff;
      best_id_in  = best_id_ff;
      best_val_in = best_val_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in    = 1'b1;
         best_id_in  = ctl.id;
         best_val_in = value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_id_ff  <= best_id_in;
      best_val_ff <= best_val_in;
   end

   assign sts.take     = take;
   assign sts.found    = found_ff;
   assign sts.best_id  = best_id_ff;
   assign sts.best_val = best_val_ff;

endmodule

`default_nettype wire

FILE: hdl/osrv_seq.sv
// Sequencer: request handling, scan stepping, counters and the response register.
`default_nettype none

module osrv_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   osrv_req_if.sink                     req_port,
   osrv_rsp_if.source                   rsp_port,
   output      osrv_pkg::ram_ctl_type   ram_ctl,
   output      osrv_pkg::scan_ctl_type  scan_ctl,
   input  wire osrv_pkg::scan_sts_type  scan_sts
);

   osrv_pkg::state_type               state_ff, state_in;
   logic [osrv_pkg::ID_BITS-1:0]      count_ff, count_in;
   logic [osrv_pkg::ID_BITS-1:0]      ptr_ff, ptr_in;
   logic [osrv_pkg::ID_BITS-1:0]      scan_id_ff, scan_id_in;
   logic                              use_scan_ff, use_scan_in;
   logic                              mode_hi_ff, mode_hi_in;
   osrv_pkg::status_type              res_status_ff, res_status_in;
   logic [osrv_pkg::ID_BITS-1:0]      res_id_ff, res_id_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   osrv_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [osrv_pkg::ID_BITS-1:0]      rsp_id_ff, rsp_id_in;

   logic accept;
   logic out_free;
   logic scan_done;
   logic oldest_ok;
   logic highest_ok;
   logic full;

   assign accept     = req_port.valid && req_port.ready;
   assign out_free   = !rsp_valid_ff || rsp_port.ready;
   assign full       = (count_ff == osrv_pkg::ID_BITS'(osrv_pkg::CAPACITY));
   assign oldest_ok  = (ptr_ff <= count_ff);
   assign highest_ok = (count_ff != '0);
   assign scan_done  = (scan_id_ff == count_ff) || (!mode_hi_ff && scan_sts.take);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         osrv_pkg::STATE_IDLE: begin
            if (accept) begin
               if ((req_port.mode == osrv_pkg::MODE_OLDEST && oldest_ok) ||
                   (req_port.mode == osrv_pkg::MODE_HIGHEST && highest_ok)) begin
                  state_in = osrv_pkg::STATE_SCAN;
               end else begin
                  state_in = osrv_pkg::STATE_POST;
               end
            end
         end
         osrv_pkg::STATE_SCAN: begin
            if (scan_done) begin
               state_in = osrv_pkg::STATE_POST;
            end
         end
         osrv_pkg::STATE_POST: begin
            if (out_free) begin
               state_in = osrv_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = osrv_pkg::STATE_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      req_port.ready   = (state_ff == osrv_pkg::STATE_IDLE);
      ram_ctl.wr_en    = 1'b0;
      ram_ctl.wr_addr  = count_ff[osrv_pkg::ADDR_BITS-1:0];
      ram_ctl.wr_data  = {1'b0, osrv_pkg::VALUE_BITS'(req_port.amount)};
      ram_ctl.rd_addr  = scan_id_ff[osrv_pkg::ADDR_BITS-1:0];
      scan_ctl.clear   = 1'b0;
      scan_ctl.eval    = 1'b0;
      scan_ctl.id      = scan_id_ff;
      count_in         = count_ff;
      ptr_in           = ptr_ff;
      scan_id_in       = scan_id_ff;
      use_scan_in      = use_scan_ff;
      mode_hi_in       = mode_hi_ff;
      res_status_in    = res_status_ff;
      res_id_in        = res_id_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_port.ready;
      rsp_status_in    = rsp_status_ff;
      rsp_id_in        = rsp_id_ff;

      case (state_ff)
         osrv_pkg::STATE_IDLE: begin
            if (accept) begin
               use_scan_in   = 1'b0;
               res_status_in = osrv_pkg::STATUS_EMPTY;
               res_id_in     = '0;
               case (req_port.mode)
                  osrv_pkg::MODE_ARRIVE: begin
                     if (full) begin
                        res_status_in = osrv_pkg::STATUS_FULL;
                     end else begin
                        ram_ctl.wr_en = 1'b1;
                        count_in      = osrv_pkg::ID_BITS'(count_ff + 1'b1);
                        res_status_in = osrv_pkg::STATUS_STORED;
                        res_id_in     = osrv_pkg::ID_BITS'(count_ff + 1'b1);
                     end
                  end
                  osrv_pkg::MODE_OLDEST: begin
                     if (oldest_ok) begin
                        use_scan_in     = 1'b1;
                        mode_hi_in      = 1'b0;
                        scan_ctl.clear  = 1'b1;
                        scan_id_in      = ptr_ff;
                        ram_ctl.rd_addr = osrv_pkg::ADDR_BITS'(ptr_ff - 1'b1);
                     end
                  end
                  osrv_pkg::MODE_HIGHEST: begin
                     if (highest_ok) begin
                        use_scan_in     = 1'b1;
                        mode_hi_in      = 1'b1;
                        scan_ctl.clear  = 1'b1;
                        scan_id_in      = osrv_pkg::ID_BITS'(1);
                        ram_ctl.rd_addr = '0;
                     end
                  end
                  default: begin
                     use_scan_in = 1'b0;
                  end
               endcase
            end
         end
         osrv_pkg::STATE_SCAN: begin
            // Data for scan_id_ff arrives now; the read for the next id goes out.
            scan_ctl.eval = 1'b1;
            scan_id_in    = osrv_pkg::ID_BITS'(scan_id_ff + 1'b1);
            if (scan_done && !mode_hi_ff) begin
               ptr_in = scan_sts.take ? scan_id_ff
                                      : osrv_pkg::ID_BITS'(count_ff + 1'b1);
            end
         end
         osrv_pkg::STATE_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (use_scan_ff) begin
                  if (scan_sts.found) begin
                     rsp_status_in   = osrv_pkg::STATUS_SERVED;
                     rsp_id_in       = scan_sts.best_id;
                     ram_ctl.wr_en   = 1'b1;
                     ram_ctl.wr_addr = osrv_pkg::ADDR_BITS'(scan_sts.best_id - 1'b1);
                     ram_ctl.wr_data = {1'b1, scan_sts.best_val};
                  end else begin
                     rsp_status_in = osrv_pkg::STATUS_EMPTY;
                     rsp_id_in     = '0;
                  end
               end else begin
                  rsp_status_in = res_status_ff;
                  rsp_id_in     = res_id_ff;
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= osrv_pkg::STATE_IDLE;
         count_ff     <= '0;
         ptr_ff       <= osrv_pkg::ID_BITS'(1);
         rsp_valid_ff <= 1'b0;
         use_scan_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         use_scan_ff  <= use_scan_in;
      end
      scan_id_ff    <= scan_id_in;
      mode_hi_ff    <= mode_hi_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.status   = rsp_status_ff;
   assign rsp_port.entry_id = rsp_id_ff;

endmodule

`default_nettype wire

FILE: dv/osrv_checker.sv
// Checker for the oldest-or-highest-value server: predicts each response item and compares it.
module osrv_checker (
   input  wire logic clock,
   input  wire logic reset,
   osrv_req_if       req_mon,
   osrv_rsp_if       rsp_mon,
   output int        failures,
   output int        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import osrv_pkg::*;

   typedef struct packed {
      status_type         status;
      logic [ID_BITS-1:0] entry_id;
   } reply_type;

   // Own copy of the waiting list; values are only read for ids already handed out.
   logic [VALUE_BITS-1:0] entry_value [CAPACITY];
   bit                    served_mark [CAPACITY];
   int unsigned           issued_ids;
   int unsigned           oldest_id;
   reply_type             replies_owed [$];
   int                    fail_count = 0;

   function automatic reply_type serve_or_store(input logic [MODE_BITS-1:0]   mode,
                                                input logic [AMOUNT_BITS-1:0] amount);
      reply_type             reply;
      int unsigned           best;
      logic [VALUE_BITS-1:0] best_value;
      reply.status   = STATUS_EMPTY;
      reply.entry_id = '0;
      best           = 0;
      best_value     = '0;
      case (mode)
         MODE_ARRIVE: begin
            if (issued_ids >= CAPACITY) begin
               reply.status = STATUS_FULL;
            end else begin
               entry_value[issued_ids] = amount[VALUE_BITS-1:0];
               served_mark[issued_ids] = 1'b0;
               issued_ids++;
               reply.status   = STATUS_STORED;
               reply.entry_id = issued_ids[ID_BITS-1:0];
            end
         end
         MODE_OLDEST: begin
            while (oldest_id <= issued_ids && served_mark[oldest_id-1])
               oldest_id++;
            if (oldest_id <= issued_ids) begin
               served_mark[oldest_id-1] = 1'b1;
               reply.status   = STATUS_SERVED;
               reply.entry_id = oldest_id[ID_BITS-1:0];
            end
         end
         MODE_HIGHEST: begin
            // Strictly greater keeps the earliest arrival on a tie.
            for (int unsigned k = 1; k <= issued_ids; k++) begin
               if (!served_mark[k-1] && (best == 0 || entry_value[k-1] > best_value)) begin
                  best       = k;
                  best_value = entry_value[k-1];
               end
            end
            if (best != 0) begin
               served_mark[best-1] = 1'b1;
               reply.status   = STATUS_SERVED;
               reply.entry_id = best[ID_BITS-1:0];
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   always @(posedge clock) begin
      reply_type owed;
      if (reset) begin
         issued_ids = 0;
         oldest_id  = 1;
         for (int i = 0; i < CAPACITY; i++)
            served_mark[i] = 1'b0;
         replies_owed.delete();
      end else begin
         // The response is handled first: it always belongs to an older request item.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (replies_owed.size() == 0) begin
               $error("unexpected response item: status %0d entry_id %0d",
                      rsp_mon.status, rsp_mon.entry_id);
               fail_count++;
            end else begin
               owed = replies_owed.pop_front();
               if (rsp_mon.status !== owed.status) begin
                  $error("status: expected %0d, got %0d", owed.status, rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.entry_id !== owed.entry_id) begin
                  $error("entry_id: expected %0d, got %0d", owed.entry_id, rsp_mon.entry_id);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            replies_owed = {replies_owed, serve_or_store(req_mon.mode, req_mon.amount)};
      end
      failures    <= fail_count;
      outstanding <= replies_owed.size();
   end

endmodule

FILE: dv/oldest_or_highest_value_server_unit_tb.sv
// Testbench top of the oldest-or-highest-value server: clock, reset, stimulus and verdict.
module oldest_or_highest_value_server_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import osrv_pkg::*;

   // Mode 3 has no member in the package; the block must treat it as nobody waiting.
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   localparam int unsigned RANDOM_ITEMS    = 424;
   // The limit must outlast a highest-value serve over a full store, the idle
   // gaps on each side and the deliberate hold-off.
   localparam int unsigned IDLE_LIMIT      = 6000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned TAIL_CYCLES     = 40;

   logic clock = 1'b0;
   logic reset;

   osrv_req_if req_ch ();
   osrv_rsp_if rsp_ch ();

   int          failures;
   int          outstanding;
   int unsigned idle_cycles = 0;

   // Shared with the receiver: no_idle turns off gaps on both sides, and a
   // nonzero hold_off_cycles makes the receiver stall that long once.
   bit          no_idle         = 1'b0;
   int unsigned hold_off_cycles = 0;

   oldest_or_highest_value_server_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   osrv_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   // Offers one request item and returns at the edge where it is taken. The
   // valid stays high when the next item follows without a gap, so it is
   // never dropped and raised within one time step.
   task automatic offer(input logic [MODE_BITS-1:0] mode, input logic [AMOUNT_BITS-1:0] amount);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(19, 0);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.mode   <= mode;
      req_ch.amount <= amount;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Stops offering until every response item owed has been taken. The first
   // edge lets the checker count the item accepted just now.
   task automatic wait_for_quiet();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Values mix full random words, a few small values that force ties, and the extremes.
   function automatic logic [AMOUNT_BITS-1:0] pick_amount();
      case ($urandom_range(3, 0))
         0:       return $urandom_range(7, 0);
         1:       return $urandom_range(1, 0) ? '1 : '0;
         default: return $urandom;
      endcase
   endfunction

   // Receiver: draws a stall before every response item, or the long hold-off when asked.
   initial begin
      int unsigned stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(19, 0);
         if (hold_off_cycles != 0) begin
            stall           = hold_off_cycles;
            hold_off_cycles = 0;
         end
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   // Watchdog: any cycle without a handshake on either channel counts toward the limit.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned pick;
      logic [MODE_BITS-1:0] mode;
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.mode   <= MODE_ARRIVE;
      req_ch.amount <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Serves and the unused mode on an empty list come first,
      // then extreme values with a tie at the top and another at zero, so that
      // the highest-value serve must prefer the earlier id and the oldest serve
      // must step over ids already taken by highest-value serves.
      offer(MODE_OLDEST, '1);
      offer(MODE_HIGHEST, '0);
      offer(MODE_UNUSED, '0);
      offer(MODE_ARRIVE, '0);
      offer(MODE_ARRIVE, '1);
      offer(MODE_ARRIVE, '1);
      offer(MODE_ARRIVE, '0);
      offer(MODE_ARRIVE, 32'd5);
      offer(MODE_HIGHEST, '1);
      offer(MODE_HIGHEST, '0);
      offer(MODE_OLDEST, '0);
      offer(MODE_OLDEST, '1);
      offer(MODE_HIGHEST, '0);
      offer(MODE_UNUSED, '1);
      offer(MODE_HIGHEST, '0);
      offer(MODE_ARRIVE, 32'h8000_0000);
      offer(MODE_ARRIVE, 32'h7FFF_FFFF);
      offer(MODE_OLDEST, '0);
      offer(MODE_HIGHEST, '0);
      offer(MODE_OLDEST, '0);
      offer(MODE_HIGHEST, '0);
      offer(MODE_OLDEST, '0);
      wait_for_quiet();

      // Random part: a mix weighted toward arrivals so the list rarely runs dry,
      // with a burst against a long receiver hold-off, a full pause, and a
      // stretch with no idling on either side.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 120) begin
            no_idle         = 1'b1;
            hold_off_cycles = HOLD_OFF_CYCLES;
         end
         if (n == 135 || n == 340)
            no_idle = 1'b0;
         if (n == 240)
            wait_for_quiet();
         if (n == 300)
            no_idle = 1'b1;
         pick = $urandom_range(19, 0);
         if (pick < 9)
            mode = MODE_ARRIVE;
         else if (pick < 13)
            mode = MODE_OLDEST;
         else if (pick < 18)
            mode = MODE_HIGHEST;
         else
            mode = MODE_UNUSED;
         offer(mode, (mode == MODE_ARRIVE) ? pick_amount() : $urandom);
      end

      // Closing part: one item of each kind before the final drain.
      offer(MODE_OLDEST, '0);
      offer(MODE_HIGHEST, '1);
      offer(MODE_UNUSED, '0);
      offer(MODE_ARRIVE, '1);

      // Let every owed response come back, then watch a little longer for strays.
      wait_for_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
